[hw/rtl/tdpt_pkg.sv]
// Shared types and constants for the trial division prime test.
// Holds the datapath widths, micro-op and condition codes, step labels
// and the control word and status structs. No dependencies.
`default_nettype none

package tdpt_pkg;

    // Datapath widths
    localparam int NUMBER_BITS = 31;
    localparam int DIV_BITS    = (NUMBER_BITS + 1) / 2 + 1;   // holds floor(sqrt(max)) + 1
    localparam int SQ_BITS     = NUMBER_BITS + 2;             // divisor squared, one step past
    localparam int REM_BITS    = DIV_BITS + 1;                // partial remainder after shift
    localparam int CNT_BITS    = $clog2(NUMBER_BITS + 1);     // remainder bit counter

    // Micro-ops
    localparam int OP_BITS = 3;
    localparam logic [OP_BITS-1:0] OP_NOP       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD      = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REM_START = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REM_STEP  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_INC       = 3'd4;
    localparam logic [OP_BITS-1:0] OP_CLR       = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SET       = 3'd6;
    localparam logic [OP_BITS-1:0] OP_EMIT      = 3'd7;

    // Jump conditions
    localparam int COND_BITS = 3;
    localparam logic [COND_BITS-1:0] C_NEVER    = 3'd0;
    localparam logic [COND_BITS-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_BITS-1:0] C_IN_IDLE  = 3'd2;
    localparam logic [COND_BITS-1:0] C_N_LT2    = 3'd3;
    localparam logic [COND_BITS-1:0] C_SQ_GT_N  = 3'd4;
    localparam logic [COND_BITS-1:0] C_NOT_LAST = 3'd5;
    localparam logic [COND_BITS-1:0] C_REM_NZ   = 3'd6;
    localparam logic [COND_BITS-1:0] C_OUT_BUSY = 3'd7;

    // Program steps
    localparam int PC_BITS = 4;
    localparam logic [PC_BITS-1:0] STEP_WAIT  = 4'd0;
    localparam logic [PC_BITS-1:0] STEP_SMALL = 4'd1;
    localparam logic [PC_BITS-1:0] STEP_TRY   = 4'd2;
    localparam logic [PC_BITS-1:0] STEP_DIV   = 4'd3;
    localparam logic [PC_BITS-1:0] STEP_NEXT  = 4'd4;
    localparam logic [PC_BITS-1:0] STEP_FAIL  = 4'd5;
    localparam logic [PC_BITS-1:0] STEP_PASS  = 4'd6;
    localparam logic [PC_BITS-1:0] STEP_EMIT  = 4'd7;
    localparam logic [PC_BITS-1:0] STEP_BACK  = 4'd8;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [COND_BITS-1:0] cond;
        logic [PC_BITS-1:0]   target;
    } ctrl_word_t;

    typedef struct packed {
        logic item_valid;
        logic n_lt2;
        logic sq_gt_n;
        logic not_last;
        logic rem_nz;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/trial_division_prime_test.sv]
// Trial division prime test. Zero and one fail at once; otherwise each divisor tried,
// from 2 upward, takes one start step, NUMBER_BITS remainder steps and one advance
// step, until a remainder is zero (composite) or the divisor squared passes the
// number (prime). One number at a time; the next beat is taken in STEP_WAIT, after
// STEP_BACK follows the registered result, even if that result still waits.
// Reset clears the step counter and the result valid flag.
`default_nettype none

module trial_division_prime_test (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [tdpt_pkg::NUMBER_BITS-1:0]  number,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   is_prime
);

    logic [tdpt_pkg::PC_BITS-1:0] pc;
    tdpt_pkg::ctrl_word_t         ctrl;
    tdpt_pkg::status_t            status;

    // Control store
    tdpt_ucode u_ucode (
        .pc   (pc),
        .ctrl (ctrl)
    );

    // Step counter
    tdpt_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .pc     (pc)
    );

    // Arithmetic and result register
    tdpt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .item_valid   (item_valid),
        .number       (number),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_prime     (is_prime),
        .status       (status)
    );

endmodule

`default_nettype wire

[hw/rtl/tdpt_ucode.sv]
// Microprogram store: one control word per step of the test.
// Depends on tdpt_pkg for the op, condition and step codes.
`default_nettype none

module tdpt_ucode (
    input  wire logic [tdpt_pkg::PC_BITS-1:0] pc,
    output tdpt_pkg::ctrl_word_t              ctrl
);

    // Program: jump to target when the condition holds, else fall through
    always_comb
    begin
        case (pc)
            tdpt_pkg::STEP_WAIT:
                ctrl = '{tdpt_pkg::OP_LOAD, tdpt_pkg::C_IN_IDLE, tdpt_pkg::STEP_WAIT};
            tdpt_pkg::STEP_SMALL:
                ctrl = '{tdpt_pkg::OP_NOP, tdpt_pkg::C_N_LT2, tdpt_pkg::STEP_FAIL};
            tdpt_pkg::STEP_TRY:
                ctrl = '{tdpt_pkg::OP_REM_START, tdpt_pkg::C_SQ_GT_N, tdpt_pkg::STEP_PASS};
            tdpt_pkg::STEP_DIV:
                ctrl = '{tdpt_pkg::OP_REM_STEP, tdpt_pkg::C_NOT_LAST, tdpt_pkg::STEP_DIV};
            tdpt_pkg::STEP_NEXT:
                ctrl = '{tdpt_pkg::OP_INC, tdpt_pkg::C_REM_NZ, tdpt_pkg::STEP_TRY};
            tdpt_pkg::STEP_FAIL:
                ctrl = '{tdpt_pkg::OP_CLR, tdpt_pkg::C_ALWAYS, tdpt_pkg::STEP_EMIT};
            tdpt_pkg::STEP_PASS:
                ctrl = '{tdpt_pkg::OP_SET, tdpt_pkg::C_NEVER, tdpt_pkg::STEP_EMIT};
            tdpt_pkg::STEP_EMIT:
                ctrl = '{tdpt_pkg::OP_EMIT, tdpt_pkg::C_OUT_BUSY, tdpt_pkg::STEP_EMIT};
            tdpt_pkg::STEP_BACK:
                ctrl = '{tdpt_pkg::OP_NOP, tdpt_pkg::C_ALWAYS, tdpt_pkg::STEP_WAIT};
            default:
                ctrl = '{tdpt_pkg::OP_NOP, tdpt_pkg::C_ALWAYS, tdpt_pkg::STEP_WAIT};
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/tdpt_seq.sv]
// Step counter with conditional jumps for the prime test microprogram.
// Depends on tdpt_pkg for the control word, status struct and codes.
`default_nettype none

module tdpt_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tdpt_pkg::ctrl_word_t         ctrl,
    input  wire tdpt_pkg::status_t            status,
    output logic [tdpt_pkg::PC_BITS-1:0]      pc
);

    logic [tdpt_pkg::PC_BITS-1:0] pc_reg;
    logic [tdpt_pkg::PC_BITS-1:0] pc_next;
    logic                         take;

    // Condition select
    always_comb
    begin
        case (ctrl.cond)
            tdpt_pkg::C_NEVER:    take = 1'b0;
            tdpt_pkg::C_ALWAYS:   take = 1'b1;
            tdpt_pkg::C_IN_IDLE:  take = !status.item_valid;
            tdpt_pkg::C_N_LT2:    take = status.n_lt2;
            tdpt_pkg::C_SQ_GT_N:  take = status.sq_gt_n;
            tdpt_pkg::C_NOT_LAST: take = status.not_last;
            tdpt_pkg::C_REM_NZ:   take = status.rem_nz;
            tdpt_pkg::C_OUT_BUSY: take = status.out_busy;
            default:              take = 1'b0;
        endcase
    end

    assign pc_next = take ? ctrl.target : pc_reg + tdpt_pkg::PC_BITS'(1);

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tdpt_pkg::STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign pc = pc_reg;

endmodule

`default_nettype wire

[hw/rtl/tdpt_datapath.sv]
// Datapath of the prime test: number, divisor, running square, a
// bit-serial remainder unit, verdict and result register.
// Depends on tdpt_pkg for widths, op codes and the shared structs.
`default_nettype none

module tdpt_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tdpt_pkg::ctrl_word_t              ctrl,
    input  wire logic                              item_valid,
    input  wire logic [tdpt_pkg::NUMBER_BITS-1:0]  number,
    output logic                                   item_ready,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   is_prime,
    output tdpt_pkg::status_t                      status
);

    localparam int NB = tdpt_pkg::NUMBER_BITS;
    localparam int DW = tdpt_pkg::DIV_BITS;
    localparam int SW = tdpt_pkg::SQ_BITS;
    localparam int RW = tdpt_pkg::REM_BITS;
    localparam int CW = tdpt_pkg::CNT_BITS;

    logic [NB-1:0] n_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] sq_reg;
    logic [RW-1:0] rem_reg;
    logic [NB-1:0] shf_reg;
    logic [CW-1:0] cnt_reg;
    logic          verdict_reg;
    logic          result_valid_reg;
    logic          is_prime_reg;

    logic [RW-1:0] rem_trial;
    logic [RW-1:0] rem_next;
    logic          out_busy;
    logic          load;

    assign item_ready = (ctrl.op == tdpt_pkg::OP_LOAD);
    assign load       = item_ready && item_valid;
    assign out_busy   = result_valid_reg && !result_ready;

    // One restoring step: bring in the next number bit, subtract if it fits
    assign rem_trial = {rem_reg[DW-1:0], shf_reg[NB-1]};
    assign rem_next  = (rem_trial >= {1'b0, div_reg}) ? rem_trial - {1'b0, div_reg}
                                                      : rem_trial;

    // Working registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            tdpt_pkg::OP_LOAD:
            begin
                if (item_valid)
                begin
                    n_reg   <= number;
                    div_reg <= DW'(2);
                    sq_reg  <= SW'(4);
                end
            end
            tdpt_pkg::OP_REM_START:
            begin
                rem_reg <= '0;
                shf_reg <= n_reg;
                cnt_reg <= CW'(NB);
            end
            tdpt_pkg::OP_REM_STEP:
            begin
                rem_reg <= rem_next;
                shf_reg <= shf_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            tdpt_pkg::OP_INC:
            begin
                // (d+1)^2 = d^2 + 2d + 1
                div_reg <= div_reg + DW'(1);
                sq_reg  <= sq_reg + SW'({div_reg, 1'b1});
            end
            tdpt_pkg::OP_CLR:  verdict_reg <= 1'b0;
            tdpt_pkg::OP_SET:  verdict_reg <= 1'b1;
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.op == tdpt_pkg::OP_EMIT && !out_busy)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == tdpt_pkg::OP_EMIT && !out_busy)
        begin
            is_prime_reg <= verdict_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign is_prime     = is_prime_reg;

    // Status flags for the sequencer
    assign status.item_valid = item_valid;
    assign status.n_lt2      = (n_reg < NB'(2));
    assign status.sq_gt_n    = (sq_reg > SW'(n_reg));
    assign status.not_last   = (cnt_reg != CW'(1));
    assign status.rem_nz     = (rem_reg != '0);
    assign status.out_busy   = out_busy;

    // Checks
    a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (div_reg == DW'(2)) && (sq_reg == SW'(4)))
        else $error("divisor or square not initialised on load");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == tdpt_pkg::OP_REM_STEP) |=> (rem_reg < {1'b0, div_reg}))
        else $error("partial remainder not below divisor");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == tdpt_pkg::OP_EMIT && !out_busy) |=>
            result_valid_reg && (is_prime_reg == $past(verdict_reg)))
        else $error("verdict not moved to result register");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == tdpt_pkg::OP_REM_STEP) |-> !item_ready)
        else $error("input open during remainder");

endmodule

`default_nettype wire

[tb/tb_trial_division_prime_test.sv]
// Self-checking bench for trial_division_prime_test: directed and random numbers
// go in, and each is_prime beat is checked against an in-bench trial division.
// Depends on tdpt_pkg and trial_division_prime_test only.
`default_nettype none

module tb_trial_division_prime_test;

    localparam int NB = tdpt_pkg::NUMBER_BITS;
    localparam logic [NB-1:0] NUMBER_MAX = {NB{1'b1}};

    typedef struct {
        logic [NB-1:0] number;
        bit            is_prime;
    } verdict_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          item_valid = 1'b0;
    logic          item_ready;
    logic [NB-1:0] number = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    logic          is_prime;

    verdict_t      pending_verdicts[$];
    int unsigned   fail_count = 0;
    bit            steady = 1'b0;    // no idling on either side while set

    trial_division_prime_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .number       (number),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_prime     (is_prime)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Trial division up to the square root, done wide so nothing overflows
    function automatic bit prime_by_trial_division(input logic [NB-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = value;
        if (n < 2)
            return 1'b0;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Result side stalls at random, about 28 percent of the time
    always @(posedge clk)
    begin
        result_ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
    end

    // Check every result beat against the oldest expected verdict
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result beat: is_prime=%0b", is_prime);
                fail_count++;
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (is_prime !== exp_v.is_prime)
                begin
                    $error("is_prime mismatch for number %0d: expected %0b, actual %0b",
                           exp_v.number, exp_v.is_prime, is_prime);
                    fail_count++;
                end
            end
        end
    end

    // Send one number; valid stays high across back-to-back beats
    task automatic send_number(input logic [NB-1:0] value);
        verdict_t v;
        if (!steady && $urandom_range(99) < 28)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 28);
        end
        item_valid <= 1'b1;
        number     <= value;
        do
            @(posedge clk);
        while (!item_ready);
        v.number   = value;
        v.is_prime = prime_by_trial_division(value);
        pending_verdicts.push_back(v);
    endtask

    // Zero, one, two, three and the first few small cases
    task automatic test_small_numbers();
        send_number(NB'(0));
        send_number(NB'(1));
        send_number(NB'(2));
        send_number(NB'(3));
        send_number(NB'(4));
        send_number(NB'(5));
        send_number(NB'(9));
        send_number(NB'(25));
        send_number(NB'(49));
    endtask

    // Top of the range; the largest value is itself prime, so this is the long one
    task automatic test_field_extremes();
        send_number(NUMBER_MAX);
        send_number(NUMBER_MAX - NB'(1));
        send_number(NB'(1) << (NB - 1));
        send_number(NB'(32'h5555_5555));
    endtask

    // Squares of primes, near-twin products and the prime 65537: the search runs to near the root
    task automatic test_root_boundary();
        send_number(NB'(121));
        send_number(NB'(169));
        send_number(NB'(10201));
        send_number(NB'(1018081));
        send_number(NB'(10403));
        send_number(NB'(1022117));
        send_number(NB'(65537));
    endtask

    task automatic test_random_small();
        repeat (25)
            send_number(NB'($urandom_range(16383)));
    endtask

    // Large random values forced to have a small factor, so the search stays short
    task automatic test_random_large_composites();
        int unsigned   small_factors[6] = '{2, 3, 5, 7, 11, 13};
        logic [NB-1:0] r;
        int unsigned   f;
        repeat (25)
        begin
            r = NB'($urandom);
            f = small_factors[$urandom_range(5)];
            send_number(r - NB'(r % f));
        end
    endtask

    task automatic test_random_medium();
        repeat (10)
            send_number(NB'($urandom_range(1048575, 16384)));
    endtask

    // Long stretch with no idling on either side
    task automatic test_steady_burst();
        steady = 1'b1;
        repeat (20)
            send_number(NB'($urandom_range(4095)));
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_numbers();
        test_field_extremes();
        test_root_boundary();
        test_random_small();
        test_random_large_composites();
        test_random_medium();
        test_steady_burst();

        // Drain outstanding verdicts, then let the block settle
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_ucode.sv
hw/rtl/tdpt_seq.sv
hw/rtl/tdpt_datapath.sv
hw/rtl/trial_division_prime_test.sv
tb/tb_trial_division_prime_test.sv
